/* sv/dtw_frame_alignment_defines.svh */
// Assertion shorthands used by dtw_frame_alignment.sv.
`ifndef DTW_FRAME_ALIGNMENT_DEFINES_SVH
`define DTW_FRAME_ALIGNMENT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DTWFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTWFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dtwfa_pkg.sv */
package dtwfa_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QRD,
        S_DIST,
        S_SQRT,
        S_CELL,
        S_TMAP,
        S_TCHK,
        S_TRD,
        S_FIN
    } t_state;

    localparam logic [1:0] OP_LOAD_REF  = 2'd0;
    localparam logic [1:0] OP_LOAD_TEST = 2'd1;
    localparam logic [1:0] OP_ALIGN     = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    localparam logic [1:0] DIR_DIAG = 2'd0;
    localparam logic [1:0] DIR_HOLD = 2'd1;
    localparam logic [1:0] DIR_JUMP = 2'd2;

    localparam logic [1:0] CFG_REF_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TEST_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHAN_COUNT = 2'd2;

    localparam logic KIND_ALIGN = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

endpackage

/* sv/dtwfa_ram.sv */
module dtwfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/dtwfa_isqrt.sv */
// Restoring integer square root, one result bit per cycle.
module dtwfa_isqrt #(
    parameter int XW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [XW-1:0]             i_radicand,
    output logic                      o_done,
    output logic [(XW+XW%2)/2-1:0]    o_root
);

    localparam int EW = XW + XW % 2;
    localparam int RW = EW / 2;
    localparam int KW = $clog2(RW + 1);

    logic [EW-1:0] r_x;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [KW-1:0] r_cnt;
    logic          r_done;

    logic [RW+2:0] w_sh;
    logic [RW+2:0] w_trial;
    logic          w_ge;

    // remainder never exceeds twice the partial root, so RW+1 bits hold it
    assign w_sh    = {r_rem, r_x[EW-1 -: 2]};
    assign w_trial = (RW+3)'({r_root, 2'b01});
    assign w_ge    = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= KW'(RW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= EW'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[EW-3:0], 2'b00};
            r_rem  <= w_ge ? (RW+1)'(w_sh - w_trial) : (RW+1)'(w_sh);
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* sv/dtw_frame_alignment.sv */
// Dynamic time warping aligner. Loads (tuser 0/1) write one Q4.11 coefficient
// per transfer, one per cycle while idle, straight into the reference/test
// coefficient RAMs. An align (tuser 2) fills the cost grid cell by cell: per
// cell the channel loop streams channel_count coefficient pairs from the two
// RAMs through subtract, square and accumulate stages, a shared bit-serial
// square root then forms a 16-bit root at default sizes (half the radicand
// width), and the cell state merges the neighbors and writes the cost row RAM
// and the direction RAM. The backtrace then writes the frame map once per
// reference frame and walks back through the direction RAM, taking hold steps
// along the test axis. An align returns one transfer with the end cost. A
// query (tuser 3) reads the frame map RAM and answers from the registered read.
// After reset the frame map is cleared entry by entry before the first transfer
// is taken; configuration writes are taken at any time but must only be issued
// while the block is idle. A finished result sits in an output register, so a
// held result does not stall loads.
`include "dtw_frame_alignment_defines.svh"

module dtw_frame_alignment
    import dtwfa_pkg::*;
#(
    parameter int MAX_FRAMES   = 256,
    parameter int MAX_CHANNELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // frame_index[7:0], channel_index[12:8],
                                       // coeff_value[28:13], zero pad
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // mapped_frame[7:0], total_cost[39:8],
                                       // cost_saturated[40], zero pad
    output logic        m_axis_tuser   // answer_kind
);

    localparam int IW   = $clog2(MAX_FRAMES);
    localparam int NW   = $clog2(MAX_CHANNELS + 1);
    localparam int CD   = MAX_FRAMES * MAX_CHANNELS;
    localparam int CAW  = $clog2(CD);
    localparam int DD   = MAX_FRAMES * MAX_FRAMES;
    localparam int DAW  = $clog2(DD);
    localparam int SUMW = 32 + $clog2(MAX_CHANNELS);
    localparam int XW   = SUMW - 6;
    localparam int RTW  = (XW + XW % 2) / 2;

    // ---------------- config registers ----------------
    logic [8:0] r_cfg_nr, r_cfg_nt;
    logic [5:0] r_cfg_nch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nr  <= 9'd1;
            r_cfg_nt  <= 9'd1;
            r_cfg_nch <= 6'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REF_COUNT:  r_cfg_nr  <= i_cfg_data;
                CFG_TEST_COUNT: r_cfg_nt  <= i_cfg_data;
                CFG_CHAN_COUNT: r_cfg_nch <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // clamped counts: last row/column index and channel count
    logic [IW-1:0] w_nr_last, w_nt_last;
    logic [NW-1:0] w_nch;

    always_comb begin
        if (r_cfg_nr == '0)                     w_nr_last = '0;
        else if (32'(r_cfg_nr) > MAX_FRAMES)    w_nr_last = IW'(MAX_FRAMES - 1);
        else                                    w_nr_last = IW'(r_cfg_nr - 9'd1);
        if (r_cfg_nt == '0)                     w_nt_last = '0;
        else if (32'(r_cfg_nt) > MAX_FRAMES)    w_nt_last = IW'(MAX_FRAMES - 1);
        else                                    w_nt_last = IW'(r_cfg_nt - 9'd1);
        if (r_cfg_nch == '0)                    w_nch = NW'(1);
        else if (32'(r_cfg_nch) > MAX_CHANNELS) w_nch = NW'(MAX_CHANNELS);
        else                                    w_nch = NW'(r_cfg_nch);
    end

    // ---------------- input fields ----------------
    logic        w_in_acc;
    logic [1:0]  w_op;
    logic [7:0]  w_fr;
    logic [4:0]  w_ch;
    logic [15:0] w_val;
    logic        w_ld_ok;
    logic        w_fr_ok;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_op     = s_axis_tuser;
    assign w_fr     = s_axis_tdata[7:0];
    assign w_ch     = s_axis_tdata[12:8];
    assign w_val    = s_axis_tdata[28:13];
    assign w_fr_ok  = (32'(w_fr) < MAX_FRAMES);
    assign w_ld_ok  = w_fr_ok && (32'(w_ch) < MAX_CHANNELS);

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [IW-1:0]        r_i, r_j;
    logic [NW-1:0]        r_n;
    logic                 r_v1, r_v2, r_v3;
    logic signed [16:0]   r_diff;
    logic [31:0]          r_sq;
    logic [SUMW-1:0]      r_acc;
    logic [31:0]          r_lf, r_dg;
    logic [31:0]          r_fin_cost;
    logic                 r_fin_sat;
    logic [IW-1:0]        r_qaddr;
    logic                 r_qoor;
    logic                 r_ovalid;
    logic                 r_okind;
    logic [7:0]           r_oframe;
    logic [31:0]          r_ocost;
    logic                 r_osat;

    // ---------------- memories ----------------
    logic [15:0] w_ref_rd, w_test_rd;
    logic [31:0] w_cost_rd;
    logic [1:0]  w_dir_rd;
    logic [7:0]  w_map_rd;

    logic           w_ref_we, w_test_we, w_cost_we, w_dir_we, w_map_we;
    logic [CAW-1:0] w_ld_addr, w_ref_ra, w_test_ra;
    logic [DAW-1:0] w_dir_addr;
    logic [IW-1:0]  w_map_ra;
    logic [7:0]     w_map_wd;
    logic [31:0]    w_cost;
    logic [1:0]     w_dir;

    assign w_ld_addr  = CAW'(w_fr) * CAW'(MAX_CHANNELS) + CAW'(w_ch);
    assign w_ref_ra   = CAW'(r_i) * CAW'(MAX_CHANNELS) + CAW'(r_n);
    assign w_test_ra  = CAW'(r_j) * CAW'(MAX_CHANNELS) + CAW'(r_n);
    assign w_dir_addr = DAW'(r_i) * DAW'(MAX_FRAMES) + DAW'(r_j);
    assign w_map_ra   = (r_state == S_IDLE) ? IW'(w_fr) : r_qaddr;
    assign w_map_wd   = (r_state == S_TMAP) ? 8'(r_j) : 8'd0;

    dtwfa_ram #(.WIDTH(16), .DEPTH(CD)) u_ref_ram (
        .i_clk(i_clk), .i_we(w_ref_we), .i_waddr(w_ld_addr), .i_wdata(w_val),
        .i_raddr(w_ref_ra), .o_rdata(w_ref_rd)
    );

    dtwfa_ram #(.WIDTH(16), .DEPTH(CD)) u_test_ram (
        .i_clk(i_clk), .i_we(w_test_we), .i_waddr(w_ld_addr), .i_wdata(w_val),
        .i_raddr(w_test_ra), .o_rdata(w_test_rd)
    );

    // single cost row: cell j reads the previous row's entry, then overwrites it
    dtwfa_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_cost_ram (
        .i_clk(i_clk), .i_we(w_cost_we), .i_waddr(r_j), .i_wdata(w_cost),
        .i_raddr(r_j), .o_rdata(w_cost_rd)
    );

    dtwfa_ram #(.WIDTH(2), .DEPTH(DD)) u_dir_ram (
        .i_clk(i_clk), .i_we(w_dir_we), .i_waddr(w_dir_addr), .i_wdata(w_dir),
        .i_raddr(w_dir_addr), .o_rdata(w_dir_rd)
    );

    dtwfa_ram #(.WIDTH(8), .DEPTH(MAX_FRAMES)) u_map_ram (
        .i_clk(i_clk), .i_we(w_map_we), .i_waddr(r_i), .i_wdata(w_map_wd),
        .i_raddr(w_map_ra), .o_rdata(w_map_rd)
    );

    // ---------------- square root ----------------
    logic           w_sq_start;
    logic           w_sq_done;
    logic [RTW-1:0] w_root;

    dtwfa_isqrt #(.XW(XW)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_radicand(r_acc[SUMW-1:6]), .o_done(w_sq_done), .o_root(w_root)
    );

    // ---------------- cell merge ----------------
    logic [31:0] w_best;
    logic [32:0] w_sum;

    always_comb begin
        if (r_i == '0) begin
            if (r_j == '0) begin
                w_best = '0;
                w_dir  = DIR_JUMP;
            end else begin
                w_best = r_lf;
                w_dir  = DIR_HOLD;
            end
        end else if (r_j == '0) begin
            w_best = w_cost_rd;
            w_dir  = DIR_JUMP;
        end else if (w_cost_rd < r_dg) begin
            if (r_lf < w_cost_rd) begin
                w_best = r_lf;
                w_dir  = DIR_HOLD;
            end else begin
                w_best = w_cost_rd;
                w_dir  = DIR_JUMP;
            end
        end else if (r_lf < r_dg) begin
            w_best = r_lf;
            w_dir  = DIR_HOLD;
        end else begin
            w_best = r_dg;
            w_dir  = DIR_DIAG;
        end
        w_sum  = 33'(w_root) + 33'(w_best);
        w_cost = w_sum[32] ? COST_MAX : w_sum[31:0];
    end

    logic w_dist_done;
    logic w_out_free;

    assign w_dist_done = (r_n == w_nch) && !r_v1 && !r_v2 && !r_v3;
    assign w_out_free  = !r_ovalid || m_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_i == IW'(MAX_FRAMES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc && w_op == OP_ALIGN)      n_state = S_DIST;
                else if (w_in_acc && w_op == OP_QUERY) n_state = S_QRD;
            end
            S_QRD:  if (w_out_free) n_state = S_IDLE;
            S_DIST: if (w_dist_done) n_state = S_SQRT;
            S_SQRT: if (w_sq_done) n_state = S_CELL;
            S_CELL: begin
                if (r_j == w_nt_last && r_i == w_nr_last) n_state = S_TMAP;
                else                                      n_state = S_DIST;
            end
            S_TMAP: n_state = S_TCHK;
            S_TCHK: begin
                if (r_j != '0 && w_dir_rd == DIR_HOLD) n_state = S_TRD;
                else if (r_i == '0)                    n_state = S_FIN;
                else                                   n_state = S_TMAP;
            end
            S_TRD:  n_state = S_TCHK;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_ref_we      = (r_state == S_IDLE) && w_in_acc && w_op == OP_LOAD_REF && w_ld_ok;
        w_test_we     = (r_state == S_IDLE) && w_in_acc && w_op == OP_LOAD_TEST && w_ld_ok;
        w_sq_start    = (r_state == S_DIST) && w_dist_done;
        w_cost_we     = (r_state == S_CELL);
        w_dir_we      = (r_state == S_CELL);
        w_map_we      = (r_state == S_CLEAR) || (r_state == S_TMAP);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_i       <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_ovalid  <= 1'b0;
            r_fin_cost <= '0;
            r_fin_sat  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_DIST) && (r_n != w_nch);
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            // result register: load on a finished query/align, else drain
            if ((r_state == S_QRD || r_state == S_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_i <= (r_i == IW'(MAX_FRAMES - 1)) ? '0 : r_i + 1'b1;
                end
                S_IDLE: begin
                    if (w_in_acc && w_op == OP_ALIGN) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_n <= '0;
                    end
                end
                S_DIST: begin
                    if (r_n != w_nch) begin
                        r_n <= r_n + 1'b1;
                    end
                end
                S_CELL: begin
                    r_n <= '0;
                    if (r_j == w_nt_last) begin
                        if (r_i == w_nr_last) begin
                            r_fin_cost <= w_cost;
                            r_fin_sat  <= (w_cost == COST_MAX);
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= '0;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_TCHK: begin
                    if (r_j != '0 && w_dir_rd == DIR_HOLD) begin
                        r_j <= r_j - 1'b1;
                    end else begin
                        if (r_j != '0 && w_dir_rd == DIR_DIAG) r_j <= r_j - 1'b1;
                        if (r_i != '0) r_i <= r_i - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    logic signed [33:0] w_sqf;
    assign w_sqf = r_diff * r_diff;

    always_ff @(posedge i_clk) begin
        r_diff <= $signed({w_ref_rd[15], w_ref_rd}) - $signed({w_test_rd[15], w_test_rd});
        r_sq   <= w_sqf[31:0];
        if ((r_state == S_IDLE) || (r_state == S_CELL)) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + SUMW'(r_sq);
        end
        if (r_state == S_CELL) begin
            r_lf <= w_cost;
            r_dg <= w_cost_rd;
        end
        if (r_state == S_IDLE && w_in_acc) begin
            r_qaddr <= IW'(w_fr);
            r_qoor  <= !w_fr_ok;
        end
        if ((r_state == S_QRD || r_state == S_FIN) && w_out_free) begin
            r_okind  <= (r_state == S_QRD) ? KIND_QUERY : KIND_ALIGN;
            r_oframe <= (r_state == S_QRD && !r_qoor) ? w_map_rd : 8'd0;
            r_ocost  <= r_fin_cost;
            r_osat   <= r_fin_sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {7'd0, r_osat, r_ocost, r_oframe};

    // ---------------- assertions ----------------
    `DTWFA_ASSERT_NOW(a_sqrt_drained, w_sq_start, !r_v1 && !r_v2 && !r_v3,
        "square root started before channel sum settled")
    `DTWFA_ASSERT_NOW(a_done_in_sqrt, w_sq_done, r_state == S_SQRT,
        "square root finished outside its wait state")
    `DTWFA_ASSERT_NOW(a_trace_col, r_state == S_TCHK, r_j <= w_nt_last,
        "backtrace column beyond last test frame")
    `DTWFA_ASSERT_NXT(a_fin_sat, r_state == S_FIN, r_fin_sat == (r_fin_cost == COST_MAX),
        "saturation flag disagrees with end cost")

endmodule
